[hdl/sort64_pkg.sv]
// shared types and constants of the 64-key sorter
// no dependencies
package sort64_pkg;

    localparam int KEY_W            = 32;
    localparam int DEFAULT_MAX_KEYS = 64;

    // broadcast control from the sequencer to every cell of the chain
    typedef struct packed {
        logic                     load;   // insert key into the sorted chain
        logic                     shift;  // move every entry one cell toward the head
        logic signed [KEY_W-1:0]  key;    // key being inserted
    } cell_ctrl_t;

endpackage

[hdl/sort64_cell.sv]
// one cell of the insertion-sort chain: holds one key and its valid flag
// depends on sort64_pkg
module sort64_cell
    import sort64_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_ctrl_t              ctrl,
    input  logic                    prev_less,
    input  logic signed [KEY_W-1:0] prev_key,
    input  logic                    prev_valid,
    input  logic signed [KEY_W-1:0] next_key,
    input  logic                    next_valid,
    output logic                    less,
    output logic signed [KEY_W-1:0] key,
    output logic                    valid
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    valid_reg;
    logic                    valid_next;

    // an empty cell ranks above every key
    assign less = !valid_reg || (ctrl.key < key_reg);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            key_next   = next_key;
            valid_next = next_valid;
        end else if (ctrl.load && less) begin
            if (prev_less) begin
                key_next   = prev_key;
                valid_next = prev_valid;
            end else begin
                key_next   = ctrl.key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

[hdl/sort_up_to_64_keys_unit.sv]
// top level of the batch sorter for up to 64 signed 32-bit keys
// depends on sort64_pkg and sort64_cell
//
// usage
//   - s_ channel: one signed key per transaction; s_tlast closes the batch,
//     and so does the MAX_KEYS-th key of a batch even without s_tlast
//   - m_ channel: the loaded keys in ascending signed order, one per
//     transaction; m_tlast marks the largest key of the batch
//   - every accepted key is inserted into a chain of MAX_KEYS cells, so the
//     chain is always sorted; empty cells rank above all keys
//   - when a batch closes the chain drains toward cell 0, whose register is
//     the output register; the first result is valid the cycle after the
//     closing transaction, then one result per cycle while m_tready is high
//   - each key is loaded into the chain and later emitted from it; the chain
//     never does an insert and a shift in the same cycle
//   - s_tready is low while a batch drains; a stall on m_tready freezes the
//     chain and holds the current result
//   - reset empties every cell and clears the key count; no clearing pass
module sort_up_to_64_keys_unit
    import sort64_pkg::*;
#(
    parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic        s_tlast,   // last_key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_key
    output logic        m_tlast    // final_out
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    // batch bookkeeping
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             drain_reg;
    logic             drain_next;

    logic             in_xact;
    logic             out_xact;
    logic             batch_close;
    logic             last_out;
    cell_ctrl_t       ctrl;

    // chain wiring
    logic signed [KEY_W-1:0] cell_key   [MAX_KEYS];
    logic                    cell_valid [MAX_KEYS];
    logic                    cell_less  [MAX_KEYS];

    assign s_tready = !drain_reg;
    assign in_xact  = s_tvalid && s_tready;

    // cell 0 is the output register
    assign m_tvalid = drain_reg && cell_valid[0];
    assign m_tdata  = cell_key[0];
    assign out_xact = m_tvalid && m_tready;
    // the head entry is the largest one when the next cell is empty
    assign last_out = (MAX_KEYS == 1) ? 1'b1 : !cell_valid[(MAX_KEYS > 1) ? 1 : 0];
    assign m_tlast  = last_out;

    assign batch_close = in_xact && (s_tlast || (cnt_reg + 1'b1 == CNT_W'(MAX_KEYS)));

    assign ctrl.load  = in_xact;
    assign ctrl.shift = out_xact;
    assign ctrl.key   = s_tdata;

    always_comb begin
        cnt_next   = cnt_reg;
        drain_next = drain_reg;
        if (in_xact) begin
            cnt_next = batch_close ? '0 : cnt_reg + 1'b1;
        end
        if (batch_close) begin
            drain_next = 1'b1;
        end else if (out_xact && last_out) begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            drain_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
        end
    end

    // row of cells: cell i looks at cell i-1 for inserts, at cell i+1 for shifts
    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
        logic                    prev_less;
        logic signed [KEY_W-1:0] prev_key;
        logic                    prev_valid;
        logic signed [KEY_W-1:0] next_key;
        logic                    next_valid;

        if (i == 0) begin : g_head
            assign prev_less  = 1'b0;
            assign prev_key   = '0;
            assign prev_valid = 1'b0;
        end else begin : g_body
            assign prev_less  = cell_less[i-1];
            assign prev_key   = cell_key[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == MAX_KEYS - 1) begin : g_tail
            assign next_key   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_key   = cell_key[i+1];
            assign next_valid = cell_valid[i+1];
        end

        sort64_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_less  (prev_less),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .next_key   (next_key),
            .next_valid (next_valid),
            .less       (cell_less[i]),
            .key        (cell_key[i]),
            .valid      (cell_valid[i])
        );
    end

endmodule

[tb/tb.sv]
// self-checking testbench for sort_up_to_64_keys_unit: batches of signed keys in,
// ascending keys out, each result compared against a software sort of the batch
// depends on sort64_pkg and sort_up_to_64_keys_unit
module tb;
    import sort64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BATCH_MAX  = DEFAULT_MAX_KEYS;
    localparam int N_ITEMS    = 370;
    localparam int RUN_LIMIT  = 200000;
    localparam int DRAIN_WAIT = 2 * BATCH_MAX + 20;
    localparam int IDLE_PCT   = 17;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
    localparam logic signed [KEY_W-1:0] PAD_KEY = KEY_MAX;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    is_last;
    } key_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    is_top;
    } sorted_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] key
    logic        s_tlast  = 1'b0; // last_key
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] sorted_key
    logic        m_tlast;         // final_out

    key_item_t               pending_q[$];
    logic signed [KEY_W-1:0] open_batch[$];
    sorted_out_t             sorted_q[$];

    int keys_sent   = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int items_queued;

    // both sides run without gaps for a stretch in the middle of the run
    wire calm = (keys_sent >= 150) && (keys_sent < 260);

    sort_up_to_64_keys_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // load one accepted key; when the batch closes, sort it and queue every key
    function automatic void load_key(key_item_t item);
        logic signed [KEY_W-1:0] keys[$];
        logic signed [KEY_W-1:0] x;
        int                      j;
        open_batch.push_back(item.key);
        if (!item.is_last && open_batch.size() < BATCH_MAX)
            return;
        keys = open_batch;
        // insertion sort, signed compare; padding never leaves the batch
        for (int i = 1; i < keys.size(); i++) begin
            x = keys[i];
            j = i;
            while (j > 0 && x < keys[j-1]) begin
                keys[j] = keys[j-1];
                j--;
            end
            keys[j] = x;
        end
        foreach (keys[i])
            sorted_q.push_back('{key: keys[i], is_top: (i == keys.size() - 1)});
        open_batch.delete();
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = '0;
                    3:       k = -1;
                    default: k = 1;
                endcase
            end
            1, 2: begin
                // narrow range, lots of equal keys
                k = $urandom_range(8);
                k = k - 4;
            end
            3: begin
                // at or just below the padding value
                k = PAD_KEY - $urandom_range(3);
            end
            4: begin
                k = KEY_MIN + $urandom_range(3);
            end
            default: begin
                k = $urandom;
            end
        endcase
        return k;
    endfunction

    function automatic void push_key(logic signed [KEY_W-1:0] k, logic last);
        pending_q.push_back('{key: k, is_last: last});
        items_queued++;
    endfunction

    // n keys with random content; the mark goes on the final key only
    function automatic void push_batch(int n, logic mark_last);
        for (int i = 0; i < n; i++)
            push_key(pick_key(), mark_last && (i == n - 1));
    endfunction

    // sender: holds an offered transaction until accepted, idles at random
    always @(posedge aclk) begin : drive
        key_item_t nxt;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                load_key('{key: s_tdata, is_last: s_tlast});
                keys_sent <= keys_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.key;
                    s_tlast  <= nxt.is_last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transaction against the oldest expected key
    always @(posedge aclk) begin : watch
        sorted_out_t exp_out;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (sorted_q.size() == 0) begin
                    $error("unexpected result: sorted_key %0d final_out %0b",
                           $signed(m_tdata), m_tlast);
                    err_count++;
                end else begin
                    exp_out = sorted_q.pop_front();
                    if (m_tdata !== exp_out.key) begin
                        $error("sorted_key: expected %0d, got %0d",
                               exp_out.key, $signed(m_tdata));
                        err_count++;
                    end
                    if (m_tlast !== exp_out.is_top) begin
                        $error("final_out: expected %0b, got %0b", exp_out.is_top, m_tlast);
                        err_count++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int n;
        items_queued = 0;

        // directed: single key batch
        push_key(32'sd5, 1'b1);
        // both extremes, reversed
        push_key(KEY_MAX, 1'b0);
        push_key(KEY_MIN, 1'b1);
        // zero, minus one, extremes and a key equal to the padding value
        push_key('0, 1'b0);
        push_key(-1, 1'b0);
        push_key(KEY_MIN, 1'b0);
        push_key(PAD_KEY, 1'b0);
        push_key(32'sd1, 1'b0);
        push_key(PAD_KEY, 1'b1);
        // equal keys
        push_key(32'sd3, 1'b0);
        push_key(32'sd3, 1'b0);
        push_key(-32'sd3, 1'b0);
        push_key(32'sd3, 1'b1);
        // repeated minimum and one maximum
        push_key(KEY_MIN, 1'b0);
        push_key(KEY_MIN, 1'b0);
        push_key(KEY_MAX, 1'b1);
        // all bits toggling in the two halves
        push_key(32'sh5555aaaa, 1'b0);
        push_key(32'shaaaa5555, 1'b1);

        // full batch closing on its own, then one marked on the 64th key
        push_batch(BATCH_MAX, 1'b0);
        push_batch(BATCH_MAX, 1'b1);
        // long run marked only on its final key: auto-close at 64, remainder closed by the mark
        push_batch(BATCH_MAX + 6, 1'b1);

        // random batches, mostly small
        while (items_queued < N_ITEMS) begin
            case ($urandom_range(9))
                0:       n = BATCH_MAX;
                1:       n = $urandom_range(BATCH_MAX - 1, 17);
                default: n = $urandom_range(16, 1);
            endcase
            if (items_queued + n > N_ITEMS + 8)
                n = $urandom_range(4, 1);
            push_batch(n, (n < BATCH_MAX) ? 1'b1 : 1'($urandom_range(1)));
        end
        // make sure the last batch is closed
        if (open_tail_needs_mark())
            push_key(pick_key(), 1'b1);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (sorted_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_count == 0 && open_batch.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // true when the queued stimulus would leave a batch open at the end
    function automatic bit open_tail_needs_mark();
        int run;
        run = 0;
        foreach (pending_q[i]) begin
            run++;
            if (pending_q[i].is_last || run == BATCH_MAX)
                run = 0;
        end
        return run != 0;
    endfunction

endmodule

[sim.f]
hdl/sort64_pkg.sv
hdl/sort64_cell.sv
hdl/sort_up_to_64_keys_unit.sv
tb/tb.sv
